FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ila_pkg.sv
// Types, constants and helpers for the implicit list allocator
`timescale 1ns / 1ps
package ila_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int TAG_DEPTH    = HEAP_BYTES / 4;
	localparam int IDX_W        = $clog2(TAG_DEPTH);
	localparam int OFF_W        = IDX_W + 4;
	localparam int TAG_W        = 17;
	localparam int INIT_CHUNK   = 4096;
	localparam int FIRST_BP     = 8;
	localparam int HEAP_END_RST = 16 + INIT_CHUNK;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSPACE = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_DISP,
		ST_S_RD, ST_S_CHK,
		ST_GROW, ST_G_H, ST_G_F, ST_G_E,
		ST_F_RD, ST_F_CHK, ST_F_H, ST_F_F,
		ST_M_P, ST_M_N, ST_M_C, ST_M_H, ST_M_F,
		ST_P_H, ST_P_F, ST_P_NH, ST_P_NF,
		ST_DONE_A, ST_DONE_F, ST_DONE_FULL, ST_DONE_IGN
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_INIT, OP_LOAD,
		OP_S_RD, OP_S_CHK,
		OP_GROW, OP_G_H, OP_G_F, OP_G_E,
		OP_F_RD, OP_F_CHK, OP_F_H, OP_F_F,
		OP_M_P, OP_M_N, OP_M_C, OP_M_H, OP_M_F,
		OP_P_H, OP_P_F, OP_P_NH, OP_P_NF,
		OP_RES_A, OP_RES_F, OP_RES_FULL, OP_RES_IGN
	} op_t;

	typedef struct packed {
		logic init_done;
		logic is_free;
		logic req_zero;
		logic srch_over;
		logic fit;
		logic end_blk;
		logic pass;
		logic grow_ok;
		logic f_lt;
		logic f_hit;
		logic split;
	} stat_t;

	function automatic logic [TAG_W-1:0] init_tag(input logic [IDX_W-1:0] idx);
		logic [TAG_W-1:0] v;
		v = '0;
		if (idx == IDX_W'(1) || idx == IDX_W'(2))
			v = TAG_W'(9);
		else if (idx == IDX_W'(3) || idx == IDX_W'((HEAP_END_RST - 8) / 4))
			v = TAG_W'(INIT_CHUNK);
		else if (idx == IDX_W'((HEAP_END_RST - 4) / 4))
			v = TAG_W'(1);
		return v;
	endfunction

endpackage

FILE: rtl/ila_dpath.sv
// Allocator datapath: tag store, block pointers and result register
`timescale 1ns / 1ps
module ila_dpath import ila_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  op_t               op,
	input  logic              cfg_wr_en,
	input  logic [16:0]       cfg_wr_data,
	input  logic              command,
	input  logic [16:0]       request_bytes,
	input  logic [15:0]       block_address,
	output stat_t             stat,
	output logic [15:0]       payload_address,
	output logic [1:0]        status
);

	logic [TAG_W-1:0] mem [TAG_DEPTH];
	logic [TAG_W-1:0] rd_q;
	logic             rd_oob_q;

	logic [IDX_W-1:0] sweep_q;
	logic [OFF_W-1:0] rover_q, heap_end_q;
	logic [16:0]      chunk_q;

	logic             cmd_q, req_zero_q, pass_q, merged_q;
	logic [OFF_W-1:0] asize_q, bp_q, size_q;
	logic [15:0]      addr_q;
	logic [TAG_W-1:0] prev_q;
	logic [15:0]      pay_q;
	logic [1:0]       st_q;

	logic [TAG_W-1:0] tag;
	logic [OFF_W-1:0] hsz, nxt_bp, asize_in, ch, ext, room, pl_size, rest;
	logic [OFF_W-1:0] ps, m_bp, m_size, rd_off, wr_off;
	logic             pa, na, split, grow_ok;
	logic             wr_go, wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [TAG_W-1:0] wr_val;

	always_comb begin
		tag      = rd_oob_q ? '0 : rd_q;
		hsz      = {{(OFF_W-TAG_W){1'b0}}, tag[TAG_W-1:3], 3'b000};
		nxt_bp   = bp_q + hsz;
		asize_in = (OFF_W'(request_bytes) + OFF_W'(15)) & ~OFF_W'(7);
		ch       = (OFF_W'(chunk_q) + OFF_W'(7)) & ~OFF_W'(7);
		ext      = (asize_q > ch) ? asize_q : ch;
		room     = OFF_W'(HEAP_BYTES) - heap_end_q;
		grow_ok  = ext <= room;
		rest     = size_q - asize_q;
		split    = rest >= OFF_W'(8);
		pl_size  = split ? asize_q : size_q;
		ps       = {{(OFF_W-TAG_W){1'b0}}, prev_q[TAG_W-1:3], 3'b000};
		pa       = prev_q[0] | (ps == '0);
		na       = tag[0];
		m_bp     = bp_q;
		m_size   = size_q;
		if (pa && !na) begin
			m_size = size_q + hsz;
		end else if (!pa && na) begin
			m_size = size_q + ps;
			m_bp   = bp_q - ps;
		end else if (!pa && !na) begin
			m_size = size_q + ps + hsz;
			m_bp   = bp_q - ps;
		end
	end

	always_comb begin
		case (op)
			OP_M_P:  rd_off = bp_q - OFF_W'(8);
			OP_M_N:  rd_off = bp_q + size_q - OFF_W'(4);
			default: rd_off = bp_q - OFF_W'(4);
		endcase
	end

	always_comb begin
		wr_go  = 1'b1;
		wr_off = bp_q - OFF_W'(4);
		wr_val = size_q[TAG_W-1:0];
		case (op)
			OP_G_H, OP_F_H: begin
			end
			OP_G_F, OP_F_F: wr_off = bp_q + size_q - OFF_W'(8);
			OP_G_E: begin
				wr_off = bp_q + size_q - OFF_W'(4);
				wr_val = TAG_W'(1);
			end
			OP_M_H: wr_go = merged_q;
			OP_M_F: begin
				wr_go  = merged_q;
				wr_off = bp_q + size_q - OFF_W'(8);
			end
			OP_P_H: wr_val = pl_size[TAG_W-1:0] | TAG_W'(1);
			OP_P_F: begin
				wr_off = bp_q + pl_size - OFF_W'(8);
				wr_val = pl_size[TAG_W-1:0] | TAG_W'(1);
			end
			OP_P_NH: begin
				wr_off = bp_q + asize_q - OFF_W'(4);
				wr_val = rest[TAG_W-1:0];
			end
			OP_P_NF: begin
				wr_off = bp_q + size_q - OFF_W'(8);
				wr_val = rest[TAG_W-1:0];
			end
			OP_INIT: wr_val = init_tag(sweep_q);
			default: wr_go = 1'b0;
		endcase
		if (op == OP_INIT) begin
			wr_en  = 1'b1;
			wr_idx = sweep_q;
		end else begin
			wr_en  = wr_go && (wr_off[OFF_W-1:IDX_W+2] == '0);
			wr_idx = wr_off[IDX_W+1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_val;
		rd_q     <= mem[rd_off[IDX_W+1:2]];
		rd_oob_q <= rd_off[OFF_W-1:IDX_W+2] != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			rover_q    <= OFF_W'(FIRST_BP);
			heap_end_q <= OFF_W'(HEAP_END_RST);
			chunk_q    <= 17'(INIT_CHUNK);
		end else begin
			if (cfg_wr_en)
				chunk_q <= cfg_wr_data;
			case (op)
				OP_INIT: sweep_q <= sweep_q + IDX_W'(1);
				OP_S_CHK: begin
					if (!tag[0] && asize_q <= hsz && hsz != '0)
						rover_q <= bp_q;
				end
				OP_G_E: heap_end_q <= heap_end_q + size_q;
				OP_M_F: begin
					if (rover_q > bp_q && rover_q < bp_q + size_q)
						rover_q <= bp_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q      <= command;
				req_zero_q <= request_bytes == '0;
				asize_q    <= asize_in;
				addr_q     <= block_address;
				bp_q       <= command ? OFF_W'(FIRST_BP) : rover_q;
				pass_q     <= 1'b0;
			end
			OP_S_CHK: begin
				if (!tag[0] && asize_q <= hsz && hsz != '0) begin
					size_q <= hsz;
				end else if (hsz == '0) begin
					if (!pass_q) begin
						bp_q   <= OFF_W'(FIRST_BP);
						pass_q <= 1'b1;
					end
				end else begin
					bp_q <= nxt_bp;
				end
			end
			OP_GROW: begin
				bp_q   <= heap_end_q;
				size_q <= ext;
			end
			OP_F_CHK: begin
				size_q <= hsz;
				if (bp_q < OFF_W'(addr_q))
					bp_q <= nxt_bp;
			end
			OP_M_N: prev_q <= tag;
			OP_M_C: begin
				merged_q <= !(pa && na);
				bp_q     <= m_bp;
				size_q   <= m_size;
			end
			OP_RES_A: begin
				pay_q <= bp_q[15:0];
				st_q  <= STAT_OK;
			end
			OP_RES_F: begin
				pay_q <= '0;
				st_q  <= STAT_OK;
			end
			OP_RES_FULL: begin
				pay_q <= '0;
				st_q  <= STAT_NOSPACE;
			end
			OP_RES_IGN: begin
				pay_q <= '0;
				st_q  <= STAT_IGNORED;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.init_done = sweep_q == IDX_W'(TAG_DEPTH - 1);
		stat.is_free   = cmd_q;
		stat.req_zero  = req_zero_q;
		stat.srch_over = pass_q && (bp_q >= rover_q);
		stat.fit       = !tag[0] && (asize_q <= hsz) && (hsz != '0);
		stat.end_blk   = hsz == '0;
		stat.pass      = pass_q;
		stat.grow_ok   = grow_ok;
		stat.f_lt      = bp_q < OFF_W'(addr_q);
		stat.f_hit     = (bp_q == OFF_W'(addr_q)) && (addr_q != 16'(FIRST_BP)) &&
		                 (hsz != '0) && tag[0];
		stat.split     = split;
	end

	assign payload_address = pay_q;
	assign status          = st_q;

endmodule

FILE: rtl/ila_ctrl.sv
// Allocator controller: sequencing state machine and response handshake
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ila_ctrl import ila_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	input  stat_t stat,
	output op_t   op
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free, res_load;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = out_valid_q;
	assign res_load  = op == OP_RES_A || op == OP_RES_F || op == OP_RES_FULL ||
	                   op == OP_RES_IGN;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:   if (stat.init_done) state_d = ST_IDLE;
			ST_IDLE:   if (req_valid) state_d = ST_DISP;
			ST_DISP: begin
				if (stat.is_free)       state_d = ST_F_RD;
				else if (stat.req_zero) state_d = ST_DONE_IGN;
				else                    state_d = ST_S_RD;
			end
			ST_S_RD:   state_d = stat.srch_over ? ST_GROW : ST_S_CHK;
			ST_S_CHK: begin
				if (stat.fit)          state_d = ST_P_H;
				else if (stat.end_blk) state_d = stat.pass ? ST_GROW : ST_S_RD;
				else                   state_d = ST_S_RD;
			end
			ST_GROW:   state_d = stat.grow_ok ? ST_G_H : ST_DONE_FULL;
			ST_G_H:    state_d = ST_G_F;
			ST_G_F:    state_d = ST_G_E;
			ST_G_E:    state_d = ST_M_P;
			ST_F_RD:   state_d = ST_F_CHK;
			ST_F_CHK: begin
				if (stat.f_lt)       state_d = stat.end_blk ? ST_DONE_IGN : ST_F_RD;
				else if (stat.f_hit) state_d = ST_F_H;
				else                 state_d = ST_DONE_IGN;
			end
			ST_F_H:    state_d = ST_F_F;
			ST_F_F:    state_d = ST_M_P;
			ST_M_P:    state_d = ST_M_N;
			ST_M_N:    state_d = ST_M_C;
			ST_M_C:    state_d = ST_M_H;
			ST_M_H:    state_d = ST_M_F;
			ST_M_F:    state_d = stat.is_free ? ST_DONE_F : ST_P_H;
			ST_P_H:    state_d = ST_P_F;
			ST_P_F:    state_d = stat.split ? ST_P_NH : ST_DONE_A;
			ST_P_NH:   state_d = ST_P_NF;
			ST_P_NF:   state_d = ST_DONE_A;
			ST_DONE_A, ST_DONE_F, ST_DONE_FULL, ST_DONE_IGN: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_INIT;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		case (state_q)
			ST_INIT:      op = OP_INIT;
			ST_IDLE:      if (req_valid) op = OP_LOAD;
			ST_S_RD:      op = OP_S_RD;
			ST_S_CHK:     op = OP_S_CHK;
			ST_GROW:      op = OP_GROW;
			ST_G_H:       op = OP_G_H;
			ST_G_F:       op = OP_G_F;
			ST_G_E:       op = OP_G_E;
			ST_F_RD:      op = OP_F_RD;
			ST_F_CHK:     op = OP_F_CHK;
			ST_F_H:       op = OP_F_H;
			ST_F_F:       op = OP_F_F;
			ST_M_P:       op = OP_M_P;
			ST_M_N:       op = OP_M_N;
			ST_M_C:       op = OP_M_C;
			ST_M_H:       op = OP_M_H;
			ST_M_F:       op = OP_M_F;
			ST_P_H:       op = OP_P_H;
			ST_P_F:       op = OP_P_F;
			ST_P_NH:      op = OP_P_NH;
			ST_P_NF:      op = OP_P_NF;
			ST_DONE_A:    if (slot_free) op = OP_RES_A;
			ST_DONE_F:    if (slot_free) op = OP_RES_F;
			ST_DONE_FULL: if (slot_free) op = OP_RES_FULL;
			ST_DONE_IGN:  if (slot_free) op = OP_RES_IGN;
			default:      op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	`CHK_IMPL(a_res_slot, res_load && out_valid_q, rsp_ready, "result overwrote a pending response")
	`CHK_NEXT(a_accept_disp, req_valid && req_ready, state_q == ST_DISP, "accepted request not dispatched")
	`CHK_IMPL(a_rsp_origin, $rose(out_valid_q), $past(state_q == ST_DONE_A || state_q == ST_DONE_F || state_q == ST_DONE_FULL || state_q == ST_DONE_IGN), "response raised outside a done state")

endmodule

FILE: rtl/implicit_list_allocator.sv
// Sequence: an allocate is dispatched, then reads and checks each tag visited, end of
// list included, and grows, merges and splits as needed; a free walks blocks from the
// heap start and merges. A result waits in its state while the previous response is unread.
// Throughput: one request at a time, bound by the single-port walk of the tag store.
// A response may wait in its output register while the next request is accepted.
// Reset: asynchronous; afterwards a clearing pass writes the initial heap into all 16384
// tag words, one per cycle, and no request is accepted until it ends.
`timescale 1ns / 1ps
module implicit_list_allocator import ila_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        command,
	input  logic [16:0] request_bytes,
	input  logic [15:0] block_address,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [15:0] payload_address,
	output logic [1:0]  status,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data
);

	op_t   op;
	stat_t stat;

	ila_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.op        (op)
	);

	ila_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.command         (command),
		.request_bytes   (request_bytes),
		.block_address   (block_address),
		.stat            (stat),
		.payload_address (payload_address),
		.status          (status)
	);

endmodule
